[sv/mbps_pkg.sv]
`timescale 1ns / 1ps

package mbps_pkg;

  // Fixed field widths of the request and result channels.
  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 8;
  localparam int LEN_W     = 9;
  localparam int RES_OFF_W = 32;

  // Configuration port geometry.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Request operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // Register selects, taken from paddr[2].
  localparam logic REG_LENGTH    = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  typedef enum logic {
    ST_RUN,
    ST_REPLAY
  } mbps_state_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic step;
    logic clear;
  } mbps_ctl_t;

  typedef struct packed {
    logic                 found;
    logic [RES_OFF_W-1:0] match_offset;
  } mbps_result_t;

endpackage

[sv/mbps_in_if.sv]
`timescale 1ns / 1ps

interface mbps_in_if import mbps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [INDEX_W-1:0] pattern_index;
  logic [BYTE_W-1:0]  pattern_value;
  logic               pattern_care;
  logic [BYTE_W-1:0]  scan_byte;
  logic               region_end;

  modport source (
    output valid, operation, pattern_index, pattern_value, pattern_care, scan_byte,
           region_end,
    input  ready
  );

  modport sink (
    input  valid, operation, pattern_index, pattern_value, pattern_care, scan_byte,
           region_end,
    output ready
  );
endinterface

[sv/mbps_out_if.sv]
`timescale 1ns / 1ps

interface mbps_out_if import mbps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [RES_OFF_W-1:0] match_offset;

  modport source (
    output valid, found, match_offset,
    input  ready
  );

  modport sink (
    input  valid, found, match_offset,
    output ready
  );
endinterface

[sv/mbps_cell.sv]
`timescale 1ns / 1ps

module mbps_cell import mbps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mbps_ctl_t         ctl,
  input  logic [BYTE_W-1:0] feed_byte,
  input  logic              load_en,
  input  logic [BYTE_W-1:0] load_value,
  input  logic              load_care,
  input  logic [BYTE_W-1:0] win_in,
  output logic [BYTE_W-1:0] win_out,
  input  logic              fwd_in,
  output logic              fwd,
  output logic              fwd_next,
  input  logic              bwd_in,
  output logic              bwd,
  output logic              bwd_next
);

  logic [BYTE_W-1:0] pat_value;
  logic              pat_care;
  logic [BYTE_W-1:0] win_byte;
  logic              entry_ok;

  // This cell's pattern entry accepts the broadcast byte when it is equal or a wildcard.
  assign entry_ok = (pat_value == feed_byte) || !pat_care;

  // Forward partial matches grow toward higher entries, backward ones toward entry 0.
  assign fwd_next = fwd_in && entry_ok;
  assign bwd_next = bwd_in && entry_ok;
  assign win_out  = win_byte;

  // Pattern entry and window byte hold payload only.
  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_value <= load_value;
      pat_care  <= load_care;
    end
    if (ctl.shift) begin
      win_byte <= win_in;
    end
  end

  // Partial match flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
      bwd <= 1'b0;
    end else if (ctl.clear) begin
      fwd <= 1'b0;
      bwd <= 1'b0;
    end else if (ctl.step) begin
      fwd <= fwd_next;
      bwd <= bwd_next;
    end
  end

endmodule

[sv/mbps_result_fifo.sv]
`timescale 1ns / 1ps

module mbps_result_fifo import mbps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  mbps_result_t wr_data,
  output logic         full,
  mbps_out_if.source   results
);

  mbps_result_t slot [2];
  logic [1:0]   count;
  logic         rd_en;
  logic         wr_idx;

  assign rd_en  = results.valid && results.ready;
  assign full   = count[1];
  assign wr_idx = (count == 2'd1) && !rd_en;

  assign results.valid        = (count != 2'd0);
  assign results.found        = slot[0].found;
  assign results.match_offset = slot[0].match_offset;

  // Occupancy of the two-entry output queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // The head advances on a read; a write lands behind whatever remains.
  always_ff @(posedge clk) begin
    if (wr_en && !wr_idx) begin
      slot[0] <= wr_data;
    end else if (rd_en) begin
      slot[0] <= slot[1];
    end
    if (wr_en && wr_idx) begin
      slot[1] <= wr_data;
    end
  end

endmodule

[sv/masked_byte_pattern_scanner.sv]
`timescale 1ns / 1ps

// Masked byte signature scanner.
// Requests arrive on the items channel. A load request writes one pattern entry
// (value and care bit); a scan request presents the next byte of a memory region,
// with region_end on the last byte. Results leave on the results channel: found=1
// with the offset of the match's lowest-address byte, or found=0 and offset 0
// when the region ends without a match. Only the first match of a region is
// reported; region_end then rearms the scanner for the next region.
// The APB port holds pattern_length at address 0 and scan_backward at address 4.
// A chain of PATTERN_MAX cells holds the window and the partial match flags, so
// a scan request is taken every cycle while no rebuild runs and the queue has
// room, and its result is registered into the result queue.
// A pattern load or register write in the middle of a region, before a match,
// makes the chain rebuild its flags from the stored window: the next request
// waits while the window ring turns once.
// A two-entry result queue lets requests keep flowing while the receiver stalls;
// the queue holds requests off only when both entries are full.
// Synchronous reset clears the queue, the region state and the flags, and sets
// pattern_length to 1 and forward order. Pattern entries hold no reset value.
module masked_byte_pattern_scanner import mbps_pkg::*; #(
  parameter int PATTERN_MAX = 256,
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  mbps_in_if.sink           items,
  mbps_out_if.source        results
);

  localparam int CNT_W  = $clog2(PATTERN_MAX);
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int NW     = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam int IW     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  mbps_state_t            state, state_next;
  logic [LEN_W-1:0]       pattern_length;
  logic                   scan_backward;
  logic [OFFSET_BITS-1:0] byte_position;
  logic                   match_reported;
  logic [FILL_W-1:0]      window_fill;
  logic                   dirty, dirty_next;
  logic [CNT_W-1:0]       replay_cnt;

  logic [NW-1:0]          len_ext, n_eff, n_less;
  logic [PATTERN_MAX-1:0] fwd, fwd_next, bwd, bwd_next, last, load_en;
  logic [BYTE_W-1:0]      win [PATTERN_MAX];
  logic [BYTE_W-1:0]      feed_byte;
  mbps_ctl_t              ctl;

  logic item_acc, scan_acc, load_acc, cfg_wr;
  logic replay_live, hit, hit_now, res_wr, res_full, dirty_set;
  logic [OFFSET_BITS-1:0] off_fwd, off_sel;
  mbps_result_t           res_data;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign item_acc = items.valid && items.ready;
  assign scan_acc = item_acc && (items.operation == OP_SCAN);
  assign load_acc = item_acc && (items.operation == OP_LOAD);

  assign items.ready = (state == ST_RUN) && !dirty && !res_full;

  // Pattern length in use: zero counts as one, long values saturate.
  assign len_ext = NW'(pattern_length);
  always_comb begin
    if (len_ext == '0) begin
      n_eff = NW'(1);
    end else if (len_ext > NW'(PATTERN_MAX)) begin
      n_eff = NW'(PATTERN_MAX);
    end else begin
      n_eff = len_ext;
    end
  end
  assign n_less = n_eff - NW'(1);

  // During a rebuild the oldest window byte is fed back into the chain.
  assign feed_byte   = (state == ST_REPLAY) ? win[PATTERN_MAX-1] : items.scan_byte;
  assign replay_live = FILL_W'(replay_cnt) < window_fill;

  // The cell chain.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic              fwd_in_k;
    logic              bwd_in_k;
    logic              care_k;
    logic [BYTE_W-1:0] win_in_k;

    assign last[k]    = (n_eff == NW'(k + 1));
    assign load_en[k] = load_acc && (IW'(items.pattern_index) == IW'(k));

    if (k == 0) begin : g_head
      // Entry 0 is always compared.
      assign fwd_in_k = 1'b1;
      assign win_in_k = feed_byte;
      assign care_k   = 1'b1;
    end else begin : g_body
      assign fwd_in_k = fwd[k-1];
      assign win_in_k = win[k-1];
      assign care_k   = items.pattern_care;
    end

    if (k == PATTERN_MAX - 1) begin : g_tail
      assign bwd_in_k = 1'b1;
    end else begin : g_inner
      assign bwd_in_k = last[k] ? 1'b1 : bwd[k+1];
    end

    mbps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .feed_byte  (feed_byte),
      .load_en    (load_en[k]),
      .load_value (items.pattern_value),
      .load_care  (care_k),
      .win_in     (win_in_k),
      .win_out    (win[k]),
      .fwd_in     (fwd_in_k),
      .fwd        (fwd[k]),
      .fwd_next   (fwd_next[k]),
      .bwd_in     (bwd_in_k),
      .bwd        (bwd[k]),
      .bwd_next   (bwd_next[k])
    );
  end

  // A full match ends at entry n-1 going forward and at entry 0 going backward.
  assign hit     = scan_backward ? bwd_next[0] : |(fwd_next & last);
  assign hit_now = !match_reported && hit;
  assign res_wr  = scan_acc && (hit_now || (items.region_end && !match_reported));

  assign off_fwd = byte_position - OFFSET_BITS'(n_less);
  assign off_sel = scan_backward ? byte_position : off_fwd;
  assign res_data.found        = hit_now;
  assign res_data.match_offset = hit_now ? RES_OFF_W'(off_sel) : '0;

  mbps_result_fifo u_result_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_data),
    .full    (res_full),
    .results (results)
  );

  // A change of pattern or registers mid-region invalidates the partial match flags.
  assign dirty_set = (load_acc || cfg_wr) && (window_fill != '0) && !match_reported;

  // Sequencer: next state and chain control.
  always_comb begin
    state_next = state;
    dirty_next = dirty || dirty_set;
    ctl        = '0;
    case (state)
      ST_RUN: begin
        if (dirty) begin
          ctl.clear  = 1'b1;
          dirty_next = dirty_set;
          state_next = ST_REPLAY;
        end else begin
          ctl.shift = scan_acc;
          ctl.step  = scan_acc;
          ctl.clear = scan_acc && items.region_end;
        end
      end
      ST_REPLAY: begin
        ctl.shift = 1'b1;
        ctl.step  = replay_live;
        ctl.clear = !replay_live;
        if (replay_cnt == '0) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      dirty <= 1'b0;
    end else begin
      state <= state_next;
      dirty <= dirty_next;
    end
  end

  // Rebuild counter walks the window ring from oldest slot to newest.
  always_ff @(posedge clk) begin
    if (rst) begin
      replay_cnt <= '0;
    end else if (state == ST_RUN) begin
      replay_cnt <= CNT_W'(PATTERN_MAX - 1);
    end else begin
      replay_cnt <= replay_cnt - CNT_W'(1);
    end
  end

  // Region state: position, fill and the reported flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      window_fill    <= '0;
      match_reported <= 1'b0;
    end else if (scan_acc) begin
      if (items.region_end) begin
        byte_position  <= '0;
        window_fill    <= '0;
        match_reported <= 1'b0;
      end else begin
        byte_position  <= byte_position + OFFSET_BITS'(1);
        match_reported <= match_reported || hit_now;
        if (window_fill != FILL_W'(PATTERN_MAX)) begin
          window_fill <= window_fill + FILL_W'(1);
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      scan_backward  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LENGTH:    pattern_length <= pwdata[LEN_W-1:0];
        REG_DIRECTION: scan_backward  <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LENGTH:    prdata = DATA_W'(pattern_length);
      REG_DIRECTION: prdata = DATA_W'(scan_backward);
      default:       prdata = '0;
    endcase
  end

`ifndef SYNTH
  // The last byte of a region leaves the scanner rearmed.
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (scan_acc && items.region_end) |=>
      (window_fill == '0 && byte_position == '0 && !match_reported))
    else $error("scanner not rearmed after region end");

  // Once a match is reported, later bytes of the region give no result.
  a_single_report: assert property (@(posedge clk) disable iff (rst)
    (scan_acc && match_reported) |-> !res_wr)
    else $error("second result in one region");

  // A stale chain always starts a full rebuild lap.
  a_replay_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && dirty) |=>
      (state == ST_REPLAY && replay_cnt == CNT_W'(PATTERN_MAX - 1)))
    else $error("rebuild did not start");

  // A rebuild lap ends when the ring is back in place.
  a_replay_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLAY && replay_cnt == '0) |=> (state == ST_RUN))
    else $error("rebuild overran its lap");
`endif

endmodule
